// ===== rtl/scq_pkg.sv =====
// ----------------------------------------------------------------------------
// scq_pkg
// shared types and constants for the step collision qualifier
// ----------------------------------------------------------------------------
`default_nettype none

package scq_pkg;

  localparam int unsigned TorqueW   = 16;
  localparam int unsigned TorqThrW  = 15;
  localparam int unsigned LengthW   = 16;
  localparam int unsigned TargetW   = 3;
  localparam int unsigned HitW      = 4;
  localparam int unsigned TicksW    = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CoolOutW  = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TORQUE_THR = 3'd0,
    REG_LENGTH_THR = 3'd1,
    REG_HIT_TARGET = 3'd2,
    REG_COOLDOWN   = 3'd3,
    REG_ARM_DELAY  = 3'd4
  } scq_reg_e;

  localparam logic [TorqThrW-1:0] TorqueThrRst = 15'd1536;
  localparam logic [LengthW-1:0]  LengthThrRst = 16'd3000;
  localparam logic [TargetW-1:0]  HitTargetRst = 3'd2;
  localparam logic [TicksW-1:0]   CooldownRst  = 16'd1000;
  localparam logic [TicksW-1:0]   ArmDelayRst  = 16'd250;

  typedef struct packed {
    logic [TorqThrW-1:0] torque_threshold;
    logic [LengthW-1:0]  length_threshold;
    logic [TargetW-1:0]  hit_target;
    logic [TicksW-1:0]   cooldown_ticks;
    logic [TicksW-1:0]   arm_delay_ticks;
  } scq_cfg_t;

  typedef struct packed {
    logic                      long_leg_selected;
    logic signed [TorqueW-1:0] left_torque;
    logic signed [TorqueW-1:0] right_torque;
    logic [LengthW-1:0]        left_length;
    logic [LengthW-1:0]        right_length;
    logic                      started;
    logic                      climbing;
  } scq_item_t;

  typedef struct packed {
    logic                climb_trigger;
    logic [HitW-1:0]     hit_level;
    logic [CoolOutW-1:0] cooldown_left;
  } scq_result_t;

endpackage

`default_nettype wire

// ===== rtl/step_collision_qualifier_top.sv =====
// ----------------------------------------------------------------------------
// step_collision_qualifier_top
// stair-bump qualifier: an input transaction is held in the input register, its result in the result register
// throughput one transaction per cycle while out_stall_i does not hold the output; the detector state
// update sits between the input register and the result register
// reset clears all detector state and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module step_collision_qualifier_top #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [scq_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [scq_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic                                long_leg_selected_i,
  input  wire logic signed [scq_pkg::TorqueW-1:0]  left_torque_i,
  input  wire logic signed [scq_pkg::TorqueW-1:0]  right_torque_i,
  input  wire logic [scq_pkg::LengthW-1:0]         left_length_i,
  input  wire logic [scq_pkg::LengthW-1:0]         right_length_i,
  input  wire logic                                started_i,
  input  wire logic                                climbing_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic                                climb_trigger_o,
  output      logic [scq_pkg::HitW-1:0]            hit_level_o,
  output      logic [scq_pkg::CoolOutW-1:0]        cooldown_left_o
);
  import scq_pkg::*;

  scq_cfg_t    cfg;
  scq_item_t   item_q;
  scq_result_t result, result_q;
  logic        in_valid_q, out_valid_q;
  logic        out_ready, step, in_fire;

  scq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.long_leg_selected <= long_leg_selected_i;
      item_q.left_torque       <= left_torque_i;
      item_q.right_torque      <= right_torque_i;
      item_q.left_length       <= left_length_i;
      item_q.right_length      <= right_length_i;
      item_q.started           <= started_i;
      item_q.climbing          <= climbing_i;
    end
  end

  scq_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign climb_trigger_o = result_q.climb_trigger;
  assign hit_level_o     = result_q.hit_level;
  assign cooldown_left_o = result_q.cooldown_left;

endmodule

`default_nettype wire

// ===== rtl/scq_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// scq_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
`default_nettype none

module scq_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [scq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [scq_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output scq_pkg::scq_cfg_t                   cfg_o
);
  import scq_pkg::*;

  scq_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.torque_threshold <= TorqueThrRst;
      cfg_q.length_threshold <= LengthThrRst;
      cfg_q.hit_target       <= HitTargetRst;
      cfg_q.cooldown_ticks   <= CooldownRst;
      cfg_q.arm_delay_ticks  <= ArmDelayRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TORQUE_THR: cfg_q.torque_threshold <= cfg_wdata_i[TorqThrW-1:0];
        REG_LENGTH_THR: cfg_q.length_threshold <= cfg_wdata_i[LengthW-1:0];
        REG_HIT_TARGET: cfg_q.hit_target       <= cfg_wdata_i[TargetW-1:0];
        REG_COOLDOWN:   cfg_q.cooldown_ticks   <= cfg_wdata_i[TicksW-1:0];
        REG_ARM_DELAY:  cfg_q.arm_delay_ticks  <= cfg_wdata_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/scq_core.sv =====
// ----------------------------------------------------------------------------
// scq_core
// per-tick qualification logic and the detector state registers
// ----------------------------------------------------------------------------
`default_nettype none

module scq_core #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  scq_pkg::scq_item_t  item_i,
  input  scq_pkg::scq_cfg_t   cfg_i,
  output scq_pkg::scq_result_t result_o
);
  import scq_pkg::*;

  localparam int unsigned MagW = TorqueW + 1;
  localparam int unsigned ExtW = TIMER_WIDTH + TicksW;

  logic                   prev_long_q, prev_long_d;
  logic [TIMER_WIDTH-1:0] arm_q, arm_d;
  logic [TIMER_WIDTH-1:0] cool_q, cool_d;
  logic [HitW-1:0]        hit_q, hit_d;

  logic [MagW-1:0]        left_mag, right_mag, thr_ext;
  logic [ExtW-1:0]        arm_ld_ext, cool_ld_ext, cool_out_ext;
  logic [TIMER_WIDTH-1:0] arm_ld, cool_ld, cool_dec;
  logic [HitW-1:0]        hit_limit, hit_tgt, hit_step;
  logic                   both_hit, qualified, trigger;

  // magnitude of q7.8 torque, most negative value maps to 32768
  assign left_mag  = item_i.left_torque[TorqueW-1]
                   ? ({1'b1, {TorqueW{1'b0}}} - {1'b0, item_i.left_torque})
                   : {1'b0, item_i.left_torque};
  assign right_mag = item_i.right_torque[TorqueW-1]
                   ? ({1'b1, {TorqueW{1'b0}}} - {1'b0, item_i.right_torque})
                   : {1'b0, item_i.right_torque};
  assign thr_ext   = {2'b00, cfg_i.torque_threshold};

  assign arm_ld_ext  = {{TIMER_WIDTH{1'b0}}, cfg_i.arm_delay_ticks};
  assign cool_ld_ext = {{TIMER_WIDTH{1'b0}}, cfg_i.cooldown_ticks};
  assign arm_ld      = arm_ld_ext[TIMER_WIDTH-1:0];
  assign cool_ld     = cool_ld_ext[TIMER_WIDTH-1:0];

  assign hit_limit = {cfg_i.hit_target, 1'b0};
  assign hit_tgt   = {1'b0, cfg_i.hit_target};

  always_comb begin
    prev_long_d = item_i.long_leg_selected;

    // arm delay
    arm_d = arm_q;
    if (item_i.long_leg_selected && !prev_long_q) begin
      arm_d = arm_ld;
    end
    if (!item_i.long_leg_selected) begin
      arm_d = '0;
    end else if (arm_d != '0) begin
      arm_d = arm_d - 1'b1;
    end

    cool_dec = (cool_q != '0) ? (cool_q - 1'b1) : cool_q;

    both_hit = (left_mag > thr_ext) && (right_mag > thr_ext) &&
               (item_i.left_length > cfg_i.length_threshold) &&
               (item_i.right_length > cfg_i.length_threshold);

    qualified = (cool_dec == '0) && (arm_d == '0) && both_hit &&
                item_i.long_leg_selected && item_i.started && !item_i.climbing;

    hit_step = hit_q;
    if (qualified) begin
      if (hit_q < hit_limit) begin
        hit_step = hit_q + 1'b1;
      end
    end else if (hit_q != '0) begin
      hit_step = hit_q - 1'b1;
    end

    trigger = (hit_step >= hit_tgt);
    hit_d   = trigger ? '0 : hit_step;
    cool_d  = trigger ? cool_ld : cool_dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_long_q <= 1'b0;
      arm_q       <= '0;
      cool_q      <= '0;
      hit_q       <= '0;
    end else if (step_i) begin
      prev_long_q <= prev_long_d;
      arm_q       <= arm_d;
      cool_q      <= cool_d;
      hit_q       <= hit_d;
    end
  end

  assign cool_out_ext = {{TicksW{1'b0}}, cool_d};

  assign result_o.climb_trigger = trigger;
  assign result_o.hit_level     = hit_d;
  assign result_o.cooldown_left = cool_out_ext[CoolOutW-1:0];

endmodule

`default_nettype wire

// ===== rtl/scq_checker.sv =====
// ----------------------------------------------------------------------------
// scq_checker
// port-level checks for the step collision qualifier
// ----------------------------------------------------------------------------
`default_nettype none

module scq_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                cfg_we_i,
  input wire logic [scq_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input wire logic [scq_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input wire logic                                in_valid_i,
  input wire logic                                in_stall_o,
  input wire logic                                long_leg_selected_i,
  input wire logic signed [scq_pkg::TorqueW-1:0]  left_torque_i,
  input wire logic signed [scq_pkg::TorqueW-1:0]  right_torque_i,
  input wire logic [scq_pkg::LengthW-1:0]         left_length_i,
  input wire logic [scq_pkg::LengthW-1:0]         right_length_i,
  input wire logic                                started_i,
  input wire logic                                climbing_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_stall_i,
  input wire logic                                climb_trigger_o,
  input wire logic [scq_pkg::HitW-1:0]            hit_level_o,
  input wire logic [scq_pkg::CoolOutW-1:0]        cooldown_left_o
);
  import scq_pkg::*;

  // an accepted transaction passes the input register and the result register to a valid output
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> ##2 out_valid_o)
    else $error("accepted transaction produced no result");

  // a trigger always clears the hit counter
  a_trig_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && climb_trigger_o) |-> (hit_level_o == '0))
    else $error("trigger with nonzero hit level");

  // the hit counter never exceeds twice the largest target
  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_level_o != {HitW{1'b1}}))
    else $error("hit level out of range");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(climb_trigger_o) && $stable(hit_level_o) &&
       $stable(cooldown_left_o)))
    else $error("stalled result changed");

endmodule

bind step_collision_qualifier_top scq_checker u_scq_checker (.*);

`default_nettype wire
